/* rtl/pfd_pkg.sv */
// types and constants of the filtered-derivative pid controller
// used by pid_filtered_derivative and its checker; depends on nothing
`default_nettype none

package pfd_pkg;

	// request fields, signed q16.16
	typedef struct packed {
		logic signed [31:0] setpoint;
		logic signed [31:0] sample;
	} pfd_in_t;

	// result fields
	typedef struct packed {
		logic signed [31:0] drive;
		logic               skipped;
	} pfd_out_t;

	// register indexes of the write port
	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_STEP_PERIOD = 3'd3,
		REG_OUT_MIN     = 3'd4,
		REG_OUT_MAX     = 3'd5,
		REG_SMOOTH_GAIN = 3'd6
	} pfd_reg_t;

	// register reset values
	localparam logic [23:0]        RST_GAIN_P      = 24'd104858;
	localparam logic [23:0]        RST_GAIN_I      = 24'd293601;
	localparam logic [23:0]        RST_GAIN_D      = 24'd0;
	localparam logic [15:0]        RST_STEP_PERIOD = 16'd328;
	localparam logic signed [31:0] RST_OUT_MIN     = -32'sd26214400;
	localparam logic signed [31:0] RST_OUT_MAX     = 32'sd26214400;
	localparam logic [16:0]        RST_SMOOTH_GAIN = 17'd65536;

	// fixed-point limits
	localparam logic [16:0]        ONE_Q16     = 17'd65536;
	localparam logic signed [41:0] INTEG_LIMIT = 42'sd13107200;
	localparam logic [49:0]        S48_MAG_MAX = 50'h0_7FFF_FFFF_FFFF;
	localparam logic [49:0]        S48_MAG_MIN = 50'h0_8000_0000_0000;

	// serial unit lengths
	localparam int DIV_BITS = 50;
	localparam int MUL_BITS = 24;

endpackage

`default_nettype wire

/* rtl/pid_filtered_derivative.sv */
// pid controller with low-pass filtered derivative, signed q16.16
// bit-serial divider for the slope and shift-add multiplier shared by all terms; uses pfd_pkg
`default_nettype none

// channel   | signals                     | moves
// ----------+-----------------------------+-------------------------------
// in        | in_valid in_stall in_data   | setpoint and sample
// out       | out_valid out_stall out_data| drive and skipped flag
// cfg       | cfg_we cfg_index cfg_data   | register writes, no read-back
//
// one request runs a restoring divider for the slope, then six shift-add multiplies,
// one multiplier bit a cycle with a bookkeeping step after each; a zero step period
// skips both and goes straight to the result.
// one request at a time; in_stall is high from accept until the result is loaded.
// a result waits in the output register while the next request is taken.
// arst_n clears the control state and the controller state and sets the registers to their reset values.

module pid_filtered_derivative (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  pfd_pkg::pfd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output pfd_pkg::pfd_out_t out_data
);
	import pfd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ERR, S_DIV, S_DIVEND, S_MUL, S_POST, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_F0, OP_F1, OP_I0, OP_I1, OP_P, OP_D
	} op_t;

	// configuration
	logic [23:0]        gain_p_q, gain_i_q, gain_d_q;
	logic [15:0]        period_q;
	logic signed [31:0] out_min_q, out_max_q;
	logic [16:0]        smooth_q;

	// controller state
	logic signed [32:0] prev_err_q;
	logic signed [31:0] integ_q;
	logic signed [47:0] slope_q;
	logic signed [31:0] prev_drive_q;

	// sequencer and work registers
	state_t             state_q;
	op_t                op_q;
	logic [5:0]         cnt_q;
	logic               skip_q;
	logic signed [32:0] err_q;
	logic [49:0]        num_q;
	logic               neg_q;
	logic [16:0]        rem_q;
	logic [49:0]        quo_q;
	logic signed [47:0] deriv_q;
	logic signed [72:0] part_q;
	logic signed [56:0] pterm_q;
	logic signed [47:0] mul_a_q;
	logic signed [48:0] mul_hi_q;
	logic [23:0]        mul_lo_q;

	// combinational helpers
	logic signed [48:0] mul_sum;
	logic signed [72:0] prod;
	logic signed [72:0] filt_acc;
	logic [17:0]        rem_sh;
	logic               rem_ge;
	logic signed [33:0] diff;
	logic [33:0]        diff_mag;
	logic [16:0]        g_eff;
	logic [16:0]        g_inv;
	logic signed [41:0] inc;
	logic signed [41:0] integ_sum;
	logic signed [59:0] total;
	logic signed [59:0] lim_lo, lim_hi;

	assign in_stall = (state_q != S_IDLE);

	// one multiplier bit per cycle: add the multiplicand, shift right
	assign mul_sum = mul_hi_q + (mul_lo_q[0] ? {mul_a_q[47], mul_a_q} : 49'sd0);
	assign prod    = {mul_hi_q, mul_lo_q};

	// one quotient bit per cycle
	assign rem_sh = {rem_q, num_q[49]};
	assign rem_ge = (rem_sh >= {2'b00, period_q});

	// error difference and its magnitude
	assign diff     = {err_q[32], err_q} - {prev_err_q[32], prev_err_q};
	assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);

	// filter coefficient, values above one act as one
	assign g_eff = (smooth_q > ONE_Q16) ? ONE_Q16 : smooth_q;
	assign g_inv = 17'(ONE_Q16 - g_eff);

	assign filt_acc  = part_q + prod;
	assign inc       = 42'($signed(prod[56:16]));
	assign integ_sum = 42'(integ_q) + inc;

	// p + i + d, widened to hold the sum
	assign total  = 60'(pterm_q) + 60'(integ_q) + 60'($signed(prod[72:16]));
	assign lim_lo = 60'(out_min_q);
	assign lim_hi = 60'(out_max_q);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= RST_GAIN_P;
			gain_i_q  <= RST_GAIN_I;
			gain_d_q  <= RST_GAIN_D;
			period_q  <= RST_STEP_PERIOD;
			out_min_q <= RST_OUT_MIN;
			out_max_q <= RST_OUT_MAX;
			smooth_q  <= RST_SMOOTH_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:      gain_p_q  <= cfg_data[23:0];
				REG_GAIN_I:      gain_i_q  <= cfg_data[23:0];
				REG_GAIN_D:      gain_d_q  <= cfg_data[23:0];
				REG_STEP_PERIOD: period_q  <= cfg_data[15:0];
				REG_OUT_MIN:     out_min_q <= $signed(cfg_data);
				REG_OUT_MAX:     out_max_q <= $signed(cfg_data);
				REG_SMOOTH_GAIN: smooth_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// sequencer, serial units, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_F0;
			cnt_q        <= '0;
			skip_q       <= 1'b0;
			prev_err_q   <= '0;
			integ_q      <= '0;
			slope_q      <= '0;
			prev_drive_q <= '0;
			out_valid    <= 1'b0;
		end else begin
			// the done state reloads the output register itself
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						err_q  <= 33'(in_data.setpoint) - 33'(in_data.sample);
						skip_q <= (period_q == 16'd0);
						state_q <= (period_q == 16'd0) ? S_DONE : S_ERR;
					end
				end
				S_ERR: begin
					num_q   <= {diff_mag, 16'd0};
					neg_q   <= !diff[33];
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_ge ? 17'(rem_sh - {2'b00, period_q}) : rem_sh[16:0];
					quo_q <= {quo_q[48:0], rem_ge};
					num_q <= {num_q[48:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_BITS - 1))
						state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					// saturate to 48 bits, then start f*(1-g)
					if (!neg_q)
						deriv_q <= (quo_q > S48_MAG_MAX) ? 48'(S48_MAG_MAX) : 48'(quo_q);
					else
						deriv_q <= (quo_q > S48_MAG_MIN) ? 48'(S48_MAG_MIN)
							: 48'(-$signed(quo_q));
					mul_a_q  <= slope_q;
					mul_hi_q <= '0;
					mul_lo_q <= 24'(g_inv);
					cnt_q    <= '0;
					op_q     <= OP_F0;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					mul_hi_q <= {mul_sum[48], mul_sum[48:1]};
					mul_lo_q <= {mul_sum[0], mul_lo_q[23:1]};
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_BITS - 1))
						state_q <= S_POST;
				end
				S_POST: begin
					mul_hi_q <= '0;
					cnt_q    <= '0;
					state_q  <= S_MUL;
					case (op_q)
						OP_F0: begin
							part_q   <= prod;
							mul_a_q  <= deriv_q;
							mul_lo_q <= 24'(g_eff);
							op_q     <= OP_F1;
						end
						OP_F1: begin
							slope_q  <= filt_acc[63:16];
							mul_a_q  <= 48'(err_q);
							mul_lo_q <= gain_i_q;
							op_q     <= OP_I0;
						end
						OP_I0: begin
							mul_a_q  <= 48'(inc);
							mul_lo_q <= 24'(period_q);
							op_q     <= OP_I1;
						end
						OP_I1: begin
							if (integ_sum > INTEG_LIMIT)
								integ_q <= 32'(INTEG_LIMIT);
							else if (integ_sum < -INTEG_LIMIT)
								integ_q <= 32'(-INTEG_LIMIT);
							else
								integ_q <= 32'(integ_sum);
							mul_a_q  <= 48'(err_q);
							mul_lo_q <= gain_p_q;
							op_q     <= OP_P;
						end
						OP_P: begin
							pterm_q  <= prod[72:16];
							mul_a_q  <= slope_q;
							mul_lo_q <= gain_d_q;
							op_q     <= OP_D;
						end
						OP_D: begin
							if (total < lim_lo)
								prev_drive_q <= out_min_q;
							else if (total > lim_hi)
								prev_drive_q <= out_max_q;
							else
								prev_drive_q <= 32'(total);
							prev_err_q <= err_q;
							state_q    <= S_DONE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid        <= 1'b1;
						out_data.drive   <= prev_drive_q;
						out_data.skipped <= skip_q;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/pfd_checker.sv */
// port-level checks of pid_filtered_derivative and the bind that attaches them
// depends on pfd_pkg and the top level's ports
`default_nettype none

module pfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input pfd_pkg::pfd_out_t out_data
);
	import pfd_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an accepted request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after accept");

	// a new result only comes out of a request in work
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without request");

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
